// ===== hw/rtl/tmag_pkg.sv =====
package tmag_pkg;

	localparam int TILE_M = 4;
	localparam int TILE_N = 4;
	localparam int TILE_K = 4;

	// Loop indices cover tile sizes up to four.
	localparam int IDX_W = 2;

	localparam int TOTAL_ACCESSES = TILE_M * TILE_K + TILE_N * TILE_K + TILE_M * TILE_N;

	localparam logic [31:0] NULL_INDEX_RST = 32'd999;
	localparam logic [15:0] MAT_DIM_RST    = 16'd16;

	typedef enum logic [2:0] {
		REG_BASE_A    = 3'd0,
		REG_BASE_B    = 3'd1,
		REG_BASE_C    = 3'd2,
		REG_NULL_IDX  = 3'd3,
		REG_MAT_ROWS  = 3'd4,
		REG_MAT_COLS  = 3'd5,
		REG_MAT_INNER = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		PORT_A = 2'd0,
		PORT_B = 2'd1,
		PORT_C = 2'd2
	} port_sel_t;

	// Takes a dimension already divided by its tile size; a dimension below one
	// tile counts as one tile.
	function automatic logic [15:0] tile_count(input logic [15:0] q);
		logic [15:0] n;
		n = q;
		if (n == 16'd0) begin
			n = 16'd1;
		end
		return n;
	endfunction

endpackage

// ===== hw/rtl/tiled_matmul_address_generator.sv =====
// Each request on the input channel starts one tile step and produces
// TILE_M*TILE_K + TILE_N*TILE_K + TILE_M*TILE_N accesses (48 at the default
// 4x4x4 tiles): the A tile row-major, then the B tile column by column, then
// the C tile, the final access flagged by last_access. One access leaves per
// cycle through a single output register while out_ready allows; a request
// passes the request stage and the access sequencer before its first access
// reaches the output register. The next request is taken while the current
// one is still being emitted, and its accesses follow with no gap. Tile counters
// advance when a request is taken. Configuration writes take effect at once and
// must only be issued while the block holds no outstanding request.
module tiled_matmul_address_generator (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wr_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        force_restart,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  port,
	output logic [29:0] word_index,
	output logic [1:0]  byte_lane,
	output logic [1:0]  bank,
	output logic        acc_final,
	output logic        layer_end,
	output logic        last_access
);
	import tmag_pkg::*;

	// Configuration registers.
	logic [31:0] base_a_q, base_b_q, base_c_q, null_idx_q;
	logic [15:0] mat_rows_q, mat_cols_q, mat_inner_q;

	// Tile counters.
	logic [15:0] row_tile_q, col_tile_q, k_tile_q;

	// Request stage.
	logic        valid_s1;
	logic        fin_s1, done_s1;
	logic [31:0] c_prod_s1, c_col_s1;

	// Access sequencer.
	logic                 busy_q;
	port_sel_t            port_sel_q;
	logic [IDX_W-1:0]     outer_q, inner_q;
	logic                 fin_q, done_q;
	logic [31:0]          c_row_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  out_port_q, out_byte_q, out_bank_q;
	logic [29:0] out_word_q;
	logic        out_fin_q, out_done_q, out_last_q;

	logic [15:0] nm, nn, nk;
	logic        fin, done, accept;
	logic [15:0] col_inc;
	logic [31:0] crow0;
	logic        out_adv, emit, load, last_now;
	logic [IDX_W-1:0] inner_lim, outer_lim;
	logic        inner_wrap, outer_wrap;
	logic [31:0] idx;
	logic [1:0]  bank_d;

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_a_q    <= '0;
			base_b_q    <= '0;
			base_c_q    <= '0;
			null_idx_q  <= NULL_INDEX_RST;
			mat_rows_q  <= MAT_DIM_RST;
			mat_cols_q  <= MAT_DIM_RST;
			mat_inner_q <= MAT_DIM_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BASE_A:    base_a_q    <= cfg_wr_data;
				REG_BASE_B:    base_b_q    <= cfg_wr_data;
				REG_BASE_C:    base_c_q    <= cfg_wr_data;
				REG_NULL_IDX:  null_idx_q  <= cfg_wr_data;
				REG_MAT_ROWS:  mat_rows_q  <= cfg_wr_data[15:0];
				REG_MAT_COLS:  mat_cols_q  <= cfg_wr_data[15:0];
				REG_MAT_INNER: mat_inner_q <= cfg_wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Tile step flags from the counters as they stand when the request is taken.
	assign nm   = tile_count(16'(mat_rows_q / TILE_M));
	assign nn   = tile_count(16'(mat_cols_q / TILE_N));
	assign nk   = tile_count(16'(mat_inner_q / TILE_K));
	assign fin  = (k_tile_q == nk - 16'd1);
	assign done = fin && (row_tile_q == nm - 16'd1) && (col_tile_q == nn - 16'd1);
	assign col_inc = col_tile_q + 16'd1;
	assign crow0   = 32'(row_tile_q) * 32'(TILE_M);

	assign out_adv  = !out_valid_q || out_ready;
	assign emit     = busy_q && out_adv;
	assign last_now = (port_sel_q == PORT_C) && (outer_q == IDX_W'(TILE_M - 1))
		&& (inner_q == IDX_W'(TILE_N - 1));
	assign load     = valid_s1 && (!busy_q || (emit && last_now));
	assign in_ready = !valid_s1 || load;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_tile_q <= '0;
			col_tile_q <= '0;
			k_tile_q   <= '0;
		end else if (accept) begin
			if (done || force_restart) begin
				row_tile_q <= '0;
				col_tile_q <= '0;
				k_tile_q   <= '0;
			end else if (fin) begin
				k_tile_q <= '0;
				if (col_inc == nn) begin
					col_tile_q <= '0;
					row_tile_q <= row_tile_q + 16'd1;
				end else begin
					col_tile_q <= col_inc;
				end
			end else begin
				k_tile_q <= k_tile_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fin_s1    <= fin;
			done_s1   <= done;
			c_prod_s1 <= crow0 * 32'(mat_cols_q);
			c_col_s1  <= 32'(col_tile_q) * 32'(TILE_N);
		end
	end

	// Loop limits of the current operand: A is i by k, B is j by k, C is i by j.
	always_comb begin
		case (port_sel_q)
			PORT_A: begin
				outer_lim = IDX_W'(TILE_M - 1);
				inner_lim = IDX_W'(TILE_K - 1);
			end
			PORT_B: begin
				outer_lim = IDX_W'(TILE_N - 1);
				inner_lim = IDX_W'(TILE_K - 1);
			end
			default: begin
				outer_lim = IDX_W'(TILE_M - 1);
				inner_lim = IDX_W'(TILE_N - 1);
			end
		endcase
	end

	assign inner_wrap = (inner_q == inner_lim);
	assign outer_wrap = inner_wrap && (outer_q == outer_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			port_sel_q <= PORT_A;
			outer_q    <= '0;
			inner_q    <= '0;
		end else if (load) begin
			busy_q     <= 1'b1;
			port_sel_q <= PORT_A;
			outer_q    <= '0;
			inner_q    <= '0;
		end else if (emit) begin
			if (last_now) begin
				busy_q <= 1'b0;
			end
			if (inner_wrap) begin
				inner_q <= '0;
				if (outer_wrap) begin
					outer_q <= '0;
					case (port_sel_q)
						PORT_A:  port_sel_q <= PORT_B;
						PORT_B:  port_sel_q <= PORT_C;
						default: port_sel_q <= PORT_A;
					endcase
				end else begin
					outer_q <= outer_q + IDX_W'(1);
				end
			end else begin
				inner_q <= inner_q + IDX_W'(1);
			end
		end
	end

	// The C row start moves down by one matrix row each time a C tile row ends.
	always_ff @(posedge clk) begin
		if (load) begin
			fin_q   <= fin_s1;
			done_q  <= done_s1;
			c_row_q <= base_c_q + c_prod_s1 + c_col_s1;
		end else if (emit && port_sel_q == PORT_C && inner_wrap) begin
			c_row_q <= c_row_q + 32'(mat_cols_q);
		end
	end

	always_comb begin
		case (port_sel_q)
			PORT_A: begin
				idx    = base_a_q + 32'(outer_q) * 32'(TILE_K) + 32'(inner_q);
				bank_d = 2'(inner_q);
			end
			PORT_B: begin
				idx    = base_b_q + 32'(inner_q) * 32'(TILE_N) + 32'(outer_q);
				bank_d = 2'(outer_q);
			end
			default: begin
				idx    = c_row_q + 32'(inner_q);
				bank_d = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_port_q <= port_sel_q;
			out_word_q <= idx[31:2];
			out_byte_q <= (idx == null_idx_q) ? 2'd0 : idx[1:0];
			out_bank_q <= bank_d;
			out_fin_q  <= fin_q;
			out_done_q <= done_q;
			out_last_q <= last_now;
		end
	end

	assign out_valid   = out_valid_q;
	assign port        = out_port_q;
	assign word_index  = out_word_q;
	assign byte_lane   = out_byte_q;
	assign bank        = out_bank_q;
	assign acc_final   = out_fin_q;
	assign layer_end   = out_done_q;
	assign last_access = out_last_q;

endmodule
